// ===== src/slu_pkg.sv =====
// Package: shared types, character codes and decode functions for the string unescaper.
package slu_pkg;

   localparam int CHAR_W = 8;

   typedef logic [CHAR_W-1:0] char_type;

   // Decoder modes; unused codes fall back to idle behavior.
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_STR      = 3'd1,
      MODE_ESC      = 3'd2,
      MODE_HEX1     = 3'd3,
      MODE_HEX2     = 3'd4,
      MODE_HEX2_BAD = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_CLOSED     = 2'd1,
      KIND_NOT_STRING = 2'd2,
      KIND_ERROR      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_END_AFTER_BACKSLASH = 2'd0,
      ERR_INVALID_ESCAPE      = 2'd1,
      ERR_UNTERMINATED        = 2'd2
   } err_type;

   localparam char_type CH_BACKSLASH = 8'h5C;
   localparam char_type CH_DQUOTE    = 8'h22;
   localparam char_type CH_SQUOTE    = 8'h27;
   localparam char_type CH_X         = 8'h78;
   localparam char_type CH_QMARK     = 8'h3F;

   // Decoder state carried from beat to beat.
   typedef struct packed {
      mode_type   mode;
      logic       quote_single;
      logic [3:0] hex_high;
   } state_type;

   // One result beat as produced by the step logic.
   typedef struct packed {
      logic     valid;
      kind_type kind;
      char_type value;
      err_type  error_code;
   } result_type;

   // Bit 4 set: not a hex digit; else bits 3:0 carry the nibble.
   function automatic logic [4:0] hex_nibble(input char_type c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // Bit 8 set: unknown escape letter; else bits 7:0 carry the value.
   function automatic logic [8:0] simple_escape(input char_type c);
      logic [8:0] r;
      case (c)
         8'h61:        r = 9'd7;
         8'h62:        r = 9'd8;
         8'h66:        r = 9'd12;
         8'h6E:        r = 9'd10;
         8'h72:        r = 9'd13;
         8'h74:        r = 9'd9;
         8'h76:        r = 9'd11;
         CH_BACKSLASH: r = {1'b0, CH_BACKSLASH};
         CH_SQUOTE:    r = {1'b0, CH_SQUOTE};
         CH_DQUOTE:    r = {1'b0, CH_DQUOTE};
         CH_QMARK:     r = {1'b0, CH_QMARK};
         default:      r = 9'h100;
      endcase
      return r;
   endfunction

endpackage

// ===== src/slu_if.sv =====
// Interfaces: source byte channel and decoded result channel.
interface slu_req_if;
   import slu_pkg::*;
   logic     valid;
   logic     ready;
   char_type ch;
   logic     text_end;

   modport source (output valid, output ch, output text_end, input ready);
   modport sink (input valid, input ch, input text_end, output ready);
endinterface

interface slu_rsp_if;
   import slu_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   char_type   value;
   logic [1:0] error_code;

   modport source (output valid, output kind, output value, output error_code, input ready);
   modport sink (input valid, input kind, input value, input error_code, output ready);
endinterface

// ===== src/slu_step.sv =====
// Step logic: next decoder state and optional result for one source beat.
module slu_step (
   input  slu_pkg::state_type  cur,
   input  slu_pkg::char_type   ch,
   input  logic                text_end,
   output slu_pkg::state_type  nxt,
   output slu_pkg::result_type res
);
   import slu_pkg::*;

   logic [4:0] nib;
   logic [8:0] esc;
   char_type   close_q;

   assign nib     = hex_nibble(ch);
   assign esc     = simple_escape(ch);
   assign close_q = cur.quote_single ? CH_SQUOTE : CH_DQUOTE;

   always_comb begin
      nxt = cur;
      res = '0;
      if (text_end && cur.mode != MODE_IDLE && cur.mode <= MODE_HEX2_BAD) begin
         // text ran out inside a literal
         nxt.mode  = MODE_IDLE;
         res.valid = 1'b1;
         res.kind  = KIND_ERROR;
         if (cur.mode == MODE_STR) begin
            res.error_code = ERR_UNTERMINATED;
         end else if (cur.mode == MODE_ESC) begin
            res.error_code = ERR_END_AFTER_BACKSLASH;
         end else begin
            res.error_code = ERR_INVALID_ESCAPE;
         end
      end else begin
         unique case (cur.mode) inside
            MODE_STR: begin
               if (ch == CH_BACKSLASH) begin
                  nxt.mode = MODE_ESC;
               end else if (ch == close_q) begin
                  nxt.mode  = MODE_IDLE;
                  res.valid = 1'b1;
                  res.kind  = KIND_CLOSED;
               end else begin
                  res.valid = 1'b1;
                  res.kind  = KIND_BYTE;
                  res.value = ch;
               end
            end
            MODE_ESC: begin
               if (ch == CH_X) begin
                  nxt.mode = MODE_HEX1;
               end else if (esc[8]) begin
                  nxt.mode       = MODE_IDLE;
                  res.valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_INVALID_ESCAPE;
               end else begin
                  nxt.mode  = MODE_STR;
                  res.valid = 1'b1;
                  res.kind  = KIND_BYTE;
                  res.value = esc[7:0];
               end
            end
            MODE_HEX1: begin
               // keep consuming two digits even when the first is bad
               nxt.mode     = nib[4] ? MODE_HEX2_BAD : MODE_HEX2;
               nxt.hex_high = nib[4] ? 4'h0 : nib[3:0];
            end
            MODE_HEX2, MODE_HEX2_BAD: begin
               res.valid = 1'b1;
               if (cur.mode == MODE_HEX2_BAD || nib[4]) begin
                  nxt.mode       = MODE_IDLE;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_INVALID_ESCAPE;
               end else begin
                  nxt.mode  = MODE_STR;
                  res.kind  = KIND_BYTE;
                  res.value = {cur.hex_high, nib[3:0]};
               end
            end
            default: begin
               // idle: look for an opening quote
               nxt.mode = MODE_IDLE;
               if (!text_end) begin
                  if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
                     nxt.quote_single = (ch == CH_SQUOTE);
                     nxt.mode         = MODE_STR;
                  end else begin
                     res.valid = 1'b1;
                     res.kind  = KIND_NOT_STRING;
                  end
               end
            end
         endcase
      end
   end

endmodule

// ===== src/string_literal_unescape.sv =====
// Top level: C string literal unescaper with registered result and skid stage.
//
//   channel   dir  handshake        payload
//   req_bus   in   valid / ready    ch[7:0], text_end
//   rsp_bus   out  valid / ready    kind[1:0], value[7:0], error_code[1:0]
//
// One source beat per cycle while the skid slot is empty; a beat's result passes through
// the step decoder into the output register, or into the skid slot when rsp_bus stalls.
// Reset (synchronous, active high) returns the decoder to idle and empties both
// result slots. When rsp_bus stalls, one more result lands in the skid slot and
// req_bus.ready drops until the skid slot drains.
module string_literal_unescape (
   input logic      clock,
   input logic      reset,
   slu_req_if.sink  req_bus,
   slu_rsp_if.source rsp_bus
);
   import slu_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type step_res;

   // output slot and skid slot
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic req_take;
   logic rsp_take;
   logic push;

   assign req_bus.ready = !skid_valid_ff;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = out_valid_ff && rsp_bus.ready;

   slu_step u_step (
      .cur      (state_ff),
      .ch       (req_bus.ch),
      .text_end (req_bus.text_end),
      .nxt      (state_in),
      .res      (step_res)
   );

   assign push = req_take && step_res.valid;

   // advance decoder state only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_IDLE, quote_single: 1'b0, hex_high: 4'h0};
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result slot steering: skid drains first, then new results fill output or skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_in = 1'b1;
            out_in       = step_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = step_res;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload holds without reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.kind       = out_ff.kind;
   assign rsp_bus.value      = out_ff.value;
   assign rsp_bus.error_code = out_ff.error_code;

   // skid slot is only ever filled behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a beat while output slot is empty");

   // value and error code are zero unless their kind calls for them
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         ((out_ff.kind == KIND_BYTE || out_ff.value == 8'h00) &&
          (out_ff.kind == KIND_ERROR ||
           out_ff.error_code == ERR_END_AFTER_BACKSLASH)))
      else $error("result payload carries stray bits");

   // an error or a close always drops the decoder back to idle
   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      (push && (step_res.kind == KIND_ERROR || step_res.kind == KIND_CLOSED))
      |=> state_ff.mode == MODE_IDLE)
      else $error("decoder left idle after an error or close");

endmodule

// ===== sim/tb.sv =====
// Testbench for string_literal_unescape: directed and random byte streams checked by a predictor.
`timescale 1ns / 1ps

module tb;
   import slu_pkg::*;

   // Run shape.
   localparam int RANDOM_ITEMS = 1350;
   localparam int CALM_ITEMS   = 150;    // tail of the run with no idling on either side
   localparam int PAUSE_AT     = 700;    // sender drains the block before this item
   localparam int LONG_HOLD    = 80;     // one long receiver stall, in cycles
   localparam int HOLD_AFTER   = 300;    // accepted beats before the long stall starts
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   // error_code reads zero on anything that is not an error.
   localparam err_type NO_ERR = ERR_END_AFTER_BACKSLASH;

   // One result beat as the checker sees it.
   typedef struct packed {
      kind_type kind;
      char_type value;
      err_type  error_code;
   } beat_type;

   // One source beat, with an optional typed-in expectation.
   typedef struct {
      char_type ch;
      logic     text_end;
      bit       typed;      // expectation below stands instead of the predictor's
      bit       has_rsp;    // typed rows only: a result is due
      kind_type kind;
      char_type value;
      err_type  error_code;
   } step_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slu_req_if req_bus ();
   slu_rsp_if rsp_bus ();

   string_literal_unescape DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Directed opening: extremes of ch, both quotes, five ways a literal can
   // end badly, and a clean close. Rows with an obvious answer carry it.
   step_row directed_tbl [29] = '{
      '{"A",          1'b0, 1'b1, 1'b1, KIND_NOT_STRING, 8'h00, NO_ERR},
      '{8'h00,        1'b1, 1'b1, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{8'hFF,        1'b0, 1'b1, 1'b1, KIND_NOT_STRING, 8'h00, NO_ERR},
      '{CH_DQUOTE,    1'b0, 1'b1, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{8'h00,        1'b0, 1'b1, 1'b1, KIND_BYTE,       8'h00, NO_ERR},
      '{8'hFF,        1'b0, 1'b1, 1'b1, KIND_BYTE,       8'hFF, NO_ERR},
      '{CH_SQUOTE,    1'b0, 1'b1, 1'b1, KIND_BYTE,       8'h27, NO_ERR},
      '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_X,         1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{"F",          1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{"f",          1'b0, 1'b1, 1'b1, KIND_BYTE,       8'hFF, NO_ERR},
      '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{"q",          1'b0, 1'b1, 1'b1, KIND_ERROR,      8'h00, ERR_INVALID_ESCAPE},
      '{CH_SQUOTE,    1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_X,         1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{"g",          1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{"0",          1'b0, 1'b1, 1'b1, KIND_ERROR,      8'h00, ERR_INVALID_ESCAPE},
      '{CH_DQUOTE,    1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{8'hFF,        1'b1, 1'b1, 1'b1, KIND_ERROR,      8'h00, ERR_END_AFTER_BACKSLASH},
      '{CH_SQUOTE,    1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{8'h00,        1'b1, 1'b1, 1'b1, KIND_ERROR,      8'h00, ERR_UNTERMINATED},
      '{CH_DQUOTE,    1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_X,         1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{8'h5A,        1'b1, 1'b1, 1'b1, KIND_ERROR,      8'h00, ERR_INVALID_ESCAPE},
      '{CH_DQUOTE,    1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00, NO_ERR},
      '{CH_DQUOTE,    1'b0, 1'b1, 1'b1, KIND_CLOSED,     8'h00, NO_ERR}
   };

   // Letters that form a one-character escape.
   char_type esc_letters [11] = '{"a", "b", "f", "n", "r", "t", "v",
                                  CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK};

   step_row  stim_q [$];       // every source beat, in offer order
   beat_type expected_q [$];   // decoded results still owed by the block

   // Predictor state.
   mode_type   dec_mode   = MODE_IDLE;
   logic       dec_single = 1'b0;
   logic [3:0] dec_hi     = 4'h0;

   int  beats_in    = 0;
   int  cycle_count = 0;
   bit  failed      = 1'b0;
   bit  calm        = 1'b0;

   // Hex digit of either case; the letters share their low bits with 1..6.
   function automatic bit hex_digit(input char_type c, output logic [3:0] nib);
      nib = 4'h0;
      if (c >= "0" && c <= "9") begin
         nib = c[3:0];
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         nib = c[3:0] + 4'd9;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit escape_value(input char_type c, output char_type v);
      v = c;
      case (c) inside
         "a":     v = 8'd7;
         "b":     v = 8'd8;
         "f":     v = 8'd12;
         "n":     v = 8'd10;
         "r":     v = 8'd13;
         "t":     v = 8'd9;
         "v":     v = 8'd11;
         CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK: v = c;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Advance the decoder by one source beat; return 1 when a result is due.
   function automatic bit decode_step(input char_type c, input logic text_end,
                                      output beat_type r);
      logic [3:0] nib;
      char_type   v;
      r = '{KIND_BYTE, 8'h00, NO_ERR};
      case (dec_mode) inside
         MODE_STR: begin
            if (text_end) begin
               dec_mode     = MODE_IDLE;
               r.kind       = KIND_ERROR;
               r.error_code = ERR_UNTERMINATED;
               return 1'b1;
            end
            if (c == CH_BACKSLASH) begin
               dec_mode = MODE_ESC;
               return 1'b0;
            end
            if (c == (dec_single ? CH_SQUOTE : CH_DQUOTE)) begin
               dec_mode = MODE_IDLE;
               r.kind   = KIND_CLOSED;
               return 1'b1;
            end
            r.value = c;
            return 1'b1;
         end
         MODE_ESC: begin
            if (text_end) begin
               dec_mode     = MODE_IDLE;
               r.kind       = KIND_ERROR;
               r.error_code = ERR_END_AFTER_BACKSLASH;
               return 1'b1;
            end
            if (c == CH_X) begin
               dec_mode = MODE_HEX1;
               return 1'b0;
            end
            if (!escape_value(c, v)) begin
               dec_mode     = MODE_IDLE;
               r.kind       = KIND_ERROR;
               r.error_code = ERR_INVALID_ESCAPE;
               return 1'b1;
            end
            dec_mode = MODE_STR;
            r.value  = v;
            return 1'b1;
         end
         MODE_HEX1: begin
            if (text_end) begin
               dec_mode     = MODE_IDLE;
               r.kind       = KIND_ERROR;
               r.error_code = ERR_INVALID_ESCAPE;
               return 1'b1;
            end
            // A bad first digit still swallows the second byte.
            if (hex_digit(c, nib)) begin
               dec_hi   = nib;
               dec_mode = MODE_HEX2;
            end else begin
               dec_hi   = 4'h0;
               dec_mode = MODE_HEX2_BAD;
            end
            return 1'b0;
         end
         MODE_HEX2, MODE_HEX2_BAD: begin
            if (text_end || dec_mode == MODE_HEX2_BAD || !hex_digit(c, nib)) begin
               dec_mode     = MODE_IDLE;
               r.kind       = KIND_ERROR;
               r.error_code = ERR_INVALID_ESCAPE;
               return 1'b1;
            end
            dec_mode = MODE_STR;
            r.value  = {dec_hi, nib};
            return 1'b1;
         end
         default: begin
            // Idle, or a mode code that is never used.
            dec_mode = MODE_IDLE;
            if (text_end) begin
               return 1'b0;
            end
            if (c == CH_DQUOTE || c == CH_SQUOTE) begin
               dec_single = (c == CH_SQUOTE);
               dec_mode   = MODE_STR;
               return 1'b0;
            end
            r.kind = KIND_NOT_STRING;
            return 1'b1;
         end
      endcase
   endfunction

   task automatic push_item(input char_type c, input logic text_end);
      step_row row;
      row          = '{c, text_end, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR};
      stim_q.push_back(row);
   endtask

   function automatic char_type rand_hex_char();
      int unsigned d;
      d = $urandom_range(0, 15);
      if (d < 10) begin
         return char_type'("0" + d);
      end
      return char_type'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
   endfunction

   function automatic char_type rand_byte();
      return char_type'($urandom_range(0, 255));
   endfunction

   // A quoted literal with random content; now and then it breaks off badly.
   task automatic add_literal();
      char_type    quote;
      int unsigned len;
      quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      len   = $urandom_range(0, 8);
      push_item(quote, 1'b0);
      repeat (len) begin
         case ($urandom_range(0, 9))
            5, 6: begin
               push_item(CH_BACKSLASH, 1'b0);
               push_item(esc_letters[$urandom_range(0, 10)], 1'b0);
            end
            7, 8: begin
               push_item(CH_BACKSLASH, 1'b0);
               push_item(CH_X, 1'b0);
               push_item(rand_hex_char(), 1'b0);
               push_item(rand_hex_char(), 1'b0);
            end
            9: begin
               // Break the literal one of several ways, then drop it.
               case ($urandom_range(0, 6))
                  0: push_item(rand_byte(), 1'b1);
                  1: begin
                     push_item(CH_BACKSLASH, 1'b0);
                     push_item(rand_byte(), 1'b1);
                  end
                  2: begin
                     push_item(CH_BACKSLASH, 1'b0);
                     push_item(rand_byte(), 1'b0);
                  end
                  3: begin
                     push_item(CH_BACKSLASH, 1'b0);
                     push_item(CH_X, 1'b0);
                     push_item(rand_byte(), 1'b0);
                     push_item(rand_byte(), 1'b0);
                  end
                  4: begin
                     push_item(CH_BACKSLASH, 1'b0);
                     push_item(CH_X, 1'b0);
                     push_item(rand_byte(), 1'b1);
                  end
                  5: begin
                     push_item(CH_BACKSLASH, 1'b0);
                     push_item(CH_X, 1'b0);
                     push_item(rand_hex_char(), 1'b0);
                     push_item(rand_byte(), 1'b1);
                  end
                  default: begin
                     push_item(CH_BACKSLASH, 1'b0);
                     push_item(CH_X, 1'b0);
                     push_item(rand_hex_char(), 1'b0);
                     push_item(rand_byte(), 1'b0);
                  end
               endcase
               return;
            end
            default: push_item(rand_byte(), 1'b0);
         endcase
      end
      push_item(quote, 1'b0);
   endtask

   // Clock: 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hold reset high from the start, then release it once.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Monitor: retire results against the oldest expectation, then predict
   // for the source beat taken at this edge. Both sides are sampled before
   // any update of this edge lands.
   always @(posedge clock) begin : monitor
      beat_type want;
      beat_type pred;
      bit       due;
      step_row  row;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               $error("result with nothing expected: kind %0d value %0h error_code %0d",
                      rsp_bus.kind, rsp_bus.value, rsp_bus.error_code);
               failed = 1'b1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_bus.kind);
                  failed = 1'b1;
               end
               if (rsp_bus.value !== want.value) begin
                  $error("value: expected %0h, got %0h", want.value, rsp_bus.value);
                  failed = 1'b1;
               end
               if (rsp_bus.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, got %0d",
                         want.error_code, rsp_bus.error_code);
                  failed = 1'b1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            row = stim_q[beats_in];
            // Advance the predictor even where the row carries its own answer.
            due = decode_step(row.ch, row.text_end, pred);
            if (row.typed) begin
               due  = row.has_rsp;
               pred = '{row.kind, row.value, row.error_code};
            end
            if (due) begin
               expected_q.push_back(pred);
            end
            beats_in++;
         end
      end
   end

   // Receiver: random stalls in bursts, quiet stretches, one long hold-off
   // that fills the result slots and backs up the source side.
   initial begin : receiver
      int  hold_left;
      int  quiet_left;
      bit  long_done;
      hold_left  = 0;
      quiet_left = 0;
      long_done  = 1'b0;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (!long_done && beats_in >= HOLD_AFTER) begin
            long_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            hold_left = LONG_HOLD - 1;
         end else if (calm || quiet_left > 0) begin
            rsp_bus.ready <= 1'b1;
            if (quiet_left > 0) quiet_left--;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = $urandom_range(1, 11) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(20, 60);
         end
      end
   end

   // Sender: build the whole stream, then offer it beat by beat.
   initial begin : sender
      int idx;
      int quiet_left;
      quiet_left = 0;
      req_bus.valid    <= 1'b0;
      req_bus.ch       <= '0;
      req_bus.text_end <= 1'b0;

      foreach (directed_tbl[i]) stim_q.push_back(directed_tbl[i]);
      // Mostly well-formed literals; the rest is loose bytes and text ends.
      while (stim_q.size() < $size(directed_tbl) + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            add_literal();
         end else begin
            push_item(rand_byte(), $urandom_range(0, 5) == 0);
         end
      end

      wait (!reset);
      for (idx = 0; idx < stim_q.size(); idx++) begin
         if (idx >= stim_q.size() - CALM_ITEMS) calm = 1'b1;
         if (idx == PAUSE_AT) begin
            // Let the block drain completely before going on.
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (expected_q.size() != 0);
         end else if (!calm && quiet_left == 0 && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         if (quiet_left > 0) begin
            quiet_left--;
         end else if ($urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(20, 60);
         end
         // Offer the beat and hold it until the block takes it.
         req_bus.valid    <= 1'b1;
         req_bus.ch       <= stim_q[idx].ch;
         req_bus.text_end <= stim_q[idx].text_end;
         do @(posedge clock); while (!req_bus.ready);
      end
      req_bus.valid <= 1'b0;

      // Wait out the owed results, then wait on for strays.
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
